FILE: hw/rtl/prd_pkg.sv
// Shared types, codes and constants of the protection register device.
`timescale 1ns / 1ps
package prd_pkg;

    // Request kinds carried in the input tuser.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    // Bus offsets.
    localparam logic PORT_CMD  = 1'b0;
    localparam logic PORT_DATA = 1'b1;

    // Write decoding variants.
    localparam logic [1:0] VAR_FIRST  = 2'd0;
    localparam logic [1:0] VAR_SECOND = 2'd1;

    // Configuration register indexes.
    localparam logic CFG_VARIANT = 1'b0;
    localparam logic CFG_GAME_ID = 1'b1;

    // Latched command codes.
    localparam logic [15:0] CMD_REG      = 16'h0000;
    localparam logic [15:0] CMD_ONE      = 16'h0001;
    localparam logic [15:0] CMD_TWO      = 16'h0002;
    localparam logic [15:0] CMD_THREE    = 16'h0003;
    localparam logic [15:0] CMD_POINTER  = 16'h0004;
    localparam logic [15:0] CMD_ID_READ  = 16'h0005;
    localparam logic [15:0] CMD_HASH     = 16'h0020;
    localparam logic [15:0] CMD_KEY_STEP = 16'h0040;

    // Mixing and read-back constants.
    localparam logic [15:0] HOLD_XOR   = 16'h2bad;
    localparam logic [15:0] HILO_MASK  = 16'h0408;
    localparam logic [15:0] ID_PREFIX  = 16'h3f00;
    localparam logic [6:0]  LOW7_MASK  = 7'h7f;
    localparam logic [7:0]  BANK_FLAG  = 8'h80;
    localparam logic [15:0] EXEC_ONE   = 16'h0002;
    localparam logic [15:0] EXEC_TWO   = 16'h0001;

    // One result item.
    typedef struct packed {
        logic [15:0] read_data;
        logic        read_valid;
        logic        execute_pulse;
    } t_result;

endpackage

FILE: hw/rtl/prd_keytab.sv
// Key table memory with a registered read port and a same-address write bypass.
`timescale 1ns / 1ps
module prd_keytab #(
    parameter int ENTRIES = 236,
    parameter int KW      = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [KW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [KW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [ENTRIES];
    logic [7:0] r_rdata;
    logic [7:0] r_byp_data;
    logic       r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_byp_data <= i_wdata;
    end

    // A load landing on the address being read in the same cycle wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp_hit ? r_byp_data : r_rdata;

endmodule

FILE: hw/rtl/prd_core.sv
// Command decode, device state and read-back selection for one item per cycle, taken when i_accept is high.
`timescale 1ns / 1ps
module prd_core import prd_pkg::*; #(
    parameter int ENTRIES = 236,
    parameter int KW      = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [1:0]    i_req_type,
    input  logic          i_port_offset,
    input  logic [15:0]   i_bus_data,
    input  logic [7:0]    i_table_index,
    input  logic [7:0]    i_table_byte,
    input  logic [1:0]    i_variant,
    input  logic [31:0]   i_game_id,
    output t_result       o_result,
    output logic          o_kt_we,
    output logic [KW-1:0] o_kt_waddr,
    output logic [7:0]    o_kt_wdata,
    output logic [KW-1:0] o_kt_raddr,
    input  logic [7:0]    i_kt_rdata
);

    logic [15:0]   r_cmd, n_cmd;
    logic [15:0]   r_reg, n_reg;
    logic [15:0]   r_swap, n_swap;
    logic [15:0]   r_pointer, n_pointer;
    logic [15:0]   r_hold, n_hold;
    logic [15:0]   r_hilo, n_hilo;
    logic [KW-1:0] r_hilo_index, n_hilo_index;
    logic [3:0]    r_bank, n_bank;
    logic [1:0]    r_third, n_third;

    logic [KW-1:0] w_idx_next;
    logic [15:0]   w_hold_mix;
    logic [6:0]    w_swap_inc;
    logic [7:0]    w_swap_rev;
    logic [7:0]    w_scramble;
    logic [7:0]    w_id_byte;
    logic          w_id_window;
    logic          w_hash_wr;
    logic          w_key_step;

    function automatic logic [KW-1:0] next_index(input logic [KW-1:0] idx);
        logic [KW-1:0] nxt;
        nxt = (idx == KW'(ENTRIES - 1)) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

    assign w_idx_next = next_index(r_hilo_index);

    // Rotate left, then fold in the constant, the selected data bit, taps of the
    // old word and the hilo word with two bits masked off.
    always_comb begin
        w_hold_mix = {r_hold[14:0], r_hold[15]} ^ HOLD_XOR;
        w_hold_mix[0]  = w_hold_mix[0] ^ i_bus_data[r_cmd[2:0]] ^ r_hold[7];
        w_hold_mix[4]  = w_hold_mix[4] ^ ~r_hold[13];
        w_hold_mix[11] = w_hold_mix[11] ^ r_hold[3];
        w_hold_mix = w_hold_mix ^ {r_hilo[14:0] & ~HILO_MASK[14:0], 1'b0};
    end

    assign w_swap_inc = r_swap[6:0] + 7'd1;

    // Bit reversal of the low seven bits into the top seven of a byte.
    always_comb begin
        w_swap_rev = '0;
        for (int i = 0; i < 7; i++) begin
            w_swap_rev[7 - i] = w_swap_inc[i];
        end
    end

    assign w_scramble = {r_hold[5], r_hold[2], r_hold[9], r_hold[7],
                         r_hold[10], r_hold[13], r_hold[12], r_hold[15]};

    assign w_id_window = (r_pointer[15:3] == '0) && (r_pointer[2:0] != 3'd0)
                         && (r_pointer[2:0] <= 3'd4);

    always_comb begin
        case (2'(r_pointer[2:0] - 3'd1))
            2'd0:    w_id_byte = i_game_id[7:0];
            2'd1:    w_id_byte = i_game_id[15:8];
            2'd2:    w_id_byte = i_game_id[23:16];
            default: w_id_byte = i_game_id[31:24];
        endcase
    end

    assign w_hash_wr = i_accept && (i_req_type == REQ_WRITE) && (i_port_offset == PORT_DATA)
                       && (r_cmd[15:3] == CMD_HASH[15:3]);
    assign w_key_step = i_accept && (i_req_type == REQ_READ) && (i_port_offset == PORT_DATA)
                        && (r_cmd == CMD_KEY_STEP);

    always_comb begin
        n_cmd        = r_cmd;
        n_reg        = r_reg;
        n_swap       = r_swap;
        n_pointer    = r_pointer;
        n_hold       = r_hold;
        n_hilo       = r_hilo;
        n_hilo_index = r_hilo_index;
        n_bank       = r_bank;
        n_third      = r_third;
        o_result     = '0;

        if (i_accept) begin
            case (i_req_type)
                REQ_WRITE: begin
                    if (i_port_offset == PORT_CMD) begin
                        n_cmd = i_bus_data;
                    end else if (r_cmd[15:3] == CMD_HASH[15:3]) begin
                        n_pointer = r_pointer + 16'd1;
                        n_hold    = w_hold_mix;
                    end else begin
                        case (i_variant)
                            VAR_FIRST: begin
                                case (r_cmd)
                                    CMD_REG:   n_reg = i_bus_data;
                                    CMD_ONE:   o_result.execute_pulse = (i_bus_data == EXEC_ONE);
                                    CMD_TWO: begin
                                        if (i_bus_data == EXEC_TWO) begin
                                            o_result.execute_pulse = 1'b1;
                                            n_reg = r_reg + 16'd1;
                                        end
                                    end
                                    CMD_THREE: n_swap = i_bus_data;
                                    default:   ;
                                endcase
                            end
                            VAR_SECOND: begin
                                case (r_cmd)
                                    CMD_REG:     n_reg = i_bus_data;
                                    CMD_TWO:     n_bank = {i_bus_data[1], i_bus_data[0],
                                                           i_bus_data[2], i_bus_data[3]};
                                    CMD_THREE: begin
                                        o_result.execute_pulse = 1'b1;
                                        n_third = i_bus_data[5:4] + 2'd1;
                                    end
                                    CMD_POINTER: n_pointer = i_bus_data;
                                    default:     ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                REQ_READ: begin
                    o_result.read_valid = 1'b1;
                    if (i_port_offset == PORT_DATA) begin
                        case (r_cmd)
                            CMD_REG:     o_result.read_data = {8'd0, w_swap_rev};
                            CMD_ONE:     o_result.read_data = {9'd0, r_reg[6:0] & LOW7_MASK};
                            CMD_TWO:     o_result.read_data = {8'd0, BANK_FLAG | {r_bank, 4'd0}};
                            CMD_THREE:   o_result.read_data = {14'd0, r_third};
                            CMD_ID_READ: o_result.read_data = ID_PREFIX |
                                             {8'd0, w_id_window ? w_id_byte : w_scramble};
                            CMD_KEY_STEP: begin
                                n_hilo_index = w_idx_next;
                                if (w_idx_next[0]) begin
                                    n_hilo = {i_kt_rdata, r_hilo[7:0]};
                                end else begin
                                    n_hilo = {r_hilo[15:8], i_kt_rdata};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // The table is read ahead, through its registered port, at the entry the next key step will use.
    assign o_kt_raddr = next_index(n_hilo_index);
    assign o_kt_we    = i_accept && (i_req_type == REQ_LOAD)
                        && ({1'b0, i_table_index} < 9'(ENTRIES));
    assign o_kt_waddr = i_table_index[KW-1:0];
    assign o_kt_wdata = i_table_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= '0;
            r_reg        <= '0;
            r_swap       <= '0;
            r_pointer    <= '0;
            r_hold       <= '0;
            r_hilo       <= '0;
            r_hilo_index <= '0;
            r_bank       <= '0;
            r_third      <= '0;
        end else begin
            r_cmd        <= n_cmd;
            r_reg        <= n_reg;
            r_swap       <= n_swap;
            r_pointer    <= n_pointer;
            r_hold       <= n_hold;
            r_hilo       <= n_hilo;
            r_hilo_index <= n_hilo_index;
            r_bank       <= n_bank;
            r_third      <= n_third;
        end
    end

    // The key index never leaves the loaded table.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_hilo_index} < (KW + 1)'(ENTRIES))
        else $error("key index beyond table");

    // A key step moves the index to the following entry, wrapping at the end.
    a_key_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_step |=> r_hilo_index == $past(w_idx_next))
        else $error("key step index mismatch");

    // Each hash write advances the pointer by one.
    a_hash_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_wr |=> r_pointer == $past(r_pointer) + 16'd1)
        else $error("hash write did not advance pointer");

    // An execute pulse only comes from a data-port write.
    a_pulse_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.execute_pulse |-> (i_accept && i_req_type == REQ_WRITE
                                    && i_port_offset == PORT_DATA))
        else $error("execute pulse outside a data write");

endmodule

FILE: hw/rtl/protection_register_device_unit.sv
// Top level of the protection register device: stream ports, configuration and result register.
`timescale 1ns / 1ps
// The device models a bus-attached security register block with a command port
// and a data port. Each input item is one bus access (write, read or key table
// load) and produces exactly one result item in the following cycle, held in an output
// register. The block takes one item every clock cycle: the only limit on rate
// is the output register, which frees up whenever its item is taken, so a new
// item is accepted in the same cycle that the previous result leaves. The key
// table is an on-chip memory with a registered read port; the entry the next
// key step will need is fetched ahead of time, with a bypass for a load to
// that same entry, so key steps also run at one item per cycle. The key table
// is not cleared by reset and must be loaded before key steps use it. There is
// no clearing pass, so items are accepted right after reset. Configuration
// registers (variant and game identifier) are written through their own port,
// which is always ready, and should only be written while no item is in flight.
module protection_register_device_unit import prd_pkg::*; #(
    parameter int KEY_TABLE_ENTRIES = 236
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bus_data[15:0], table_index[23:16], table_byte[31:24]
    input  logic [2:0]  s_axis_tuser,   // req_type[1:0], port_offset[2]
    // Result item stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_data[15:0]
    output logic [1:0]  m_axis_tuser,   // read_valid[0], execute_pulse[1]
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int KW = (KEY_TABLE_ENTRIES > 2) ? $clog2(KEY_TABLE_ENTRIES) : 1;

    logic [1:0]    r_variant;
    logic [31:0]   r_game_id;
    logic          r_out_valid;
    t_result       r_out;

    logic          w_accept;
    t_result       w_result;
    logic          w_kt_we;
    logic [KW-1:0] w_kt_waddr;
    logic [7:0]    w_kt_wdata;
    logic [KW-1:0] w_kt_raddr;
    logic [7:0]    w_kt_rdata;

    // The output register accepts a new result whenever it is empty or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= '0;
            r_game_id <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VARIANT: r_variant <= i_cfg_data[1:0];
                CFG_GAME_ID: r_game_id <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    prd_core #(
        .ENTRIES (KEY_TABLE_ENTRIES),
        .KW      (KW)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_req_type    (s_axis_tuser[1:0]),
        .i_port_offset (s_axis_tuser[2]),
        .i_bus_data    (s_axis_tdata[15:0]),
        .i_table_index (s_axis_tdata[23:16]),
        .i_table_byte  (s_axis_tdata[31:24]),
        .i_variant     (r_variant),
        .i_game_id     (r_game_id),
        .o_result      (w_result),
        .o_kt_we       (w_kt_we),
        .o_kt_waddr    (w_kt_waddr),
        .o_kt_wdata    (w_kt_wdata),
        .o_kt_raddr    (w_kt_raddr),
        .i_kt_rdata    (w_kt_rdata)
    );

    prd_keytab #(
        .ENTRIES (KEY_TABLE_ENTRIES),
        .KW      (KW)
    ) u_keytab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_kt_we),
        .i_waddr (w_kt_waddr),
        .i_wdata (w_kt_wdata),
        .i_raddr (w_kt_raddr),
        .o_rdata (w_kt_rdata)
    );

    // Result register: loads on every accepted item, empties when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.read_data;
    assign m_axis_tuser  = {r_out.execute_pulse, r_out.read_valid};

endmodule
